// ===== rtl/chb_pkg.sv =====
// Shared types, constants and state encodings for the convex hull builder.
// Used by every module of the block but chb_ram; depends on nothing.
package chb_pkg;

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS   = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int PT_BITS    = 2 * COORD_BITS;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int SUM_BITS   = PROD_BITS + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;
	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   final_point;
	} point_word_t;

	typedef struct packed {
		coord_t vertex_x;
		coord_t vertex_y;
		cnt_t   vertex_count;
		logic   final_vertex;
		logic   overflowed;
	} vertex_word_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_PIV_INIT, ST_PIV_ICHK, ST_PIV_RD, ST_PIV_CMP, ST_SWAP0, ST_SWAP1,
		ST_SORT_ICHK, ST_KEY_RD, ST_KEY_IDX, ST_KEY_PT, ST_JCHK, ST_PREV_RD,
		ST_PREV_IDX, ST_PREV_PT, ST_S_TURN, ST_S_DK, ST_S_DP, ST_S_DEC, ST_SHIFT,
		ST_PLACE, ST_SC_INIT, ST_SC_ICHK, ST_SC_A, ST_SC_B, ST_SC_C, ST_SC_CHK,
		ST_SC_TURN, ST_SC_DEC, ST_POP, ST_POP_B, ST_POP_C, ST_PUSH, ST_OUT_INIT,
		ST_OUT_A, ST_OUT_B, ST_OUT_C
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_PIV_INIT, OP_PIV_RD, OP_PIV_CMP, OP_SWAP0, OP_SWAP1, OP_KEY_RD,
		OP_KEY_IDX, OP_KEY_PT, OP_PREV_RD, OP_PREV_IDX, OP_PREV_PT, OP_S_TURN,
		OP_S_DK, OP_S_DP, OP_SHIFT, OP_PLACE, OP_SC_INIT, OP_SC_A, OP_SC_B, OP_SC_C,
		OP_SC_TURN, OP_POP, OP_POP_B, OP_POP_C, OP_PUSH, OP_OUT_INIT, OP_OUT_A,
		OP_OUT_B, OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		logic i_lt_n;
		logic j_gt1;
		logic ahead;
		logic sp_ge2;
		logic sp_ge3;
		logic turn_le0;
		logic out_free;
		logic k_last;
	} dp_status_t;

	function automatic diff_t sub_coord(coord_t a, coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

endpackage

// ===== rtl/convex_hull_builder_top.sv =====
// Top level of the convex hull builder: joins the controller and the datapath.
// Uses chb_pkg, chb_ctrl and chb_datapath.
//
// Points load one word per cycle into a 64-entry store; more points than that
// are dropped and the run is flagged as overflowed. The word marked final_point
// starts a Graham scan, during which no point is accepted: a pivot search over
// every point, an insertion sort by angle about the pivot
// (n*n/2 comparisons at worst, n for a set already in angular order), a stack
// scan over the sorted points that pops while the turn is not to the left, and the
// hull vertices out. Every step goes through memories with one write port and one
// registered read port, and one shared pair of 17 by 17 multipliers.
// Vertices come out counter-clockwise from the pivot, the last one marked
// final_vertex.
module convex_hull_builder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  point_valid,
	output logic                  point_ready,
	input  chb_pkg::point_word_t  point,
	output logic                  vertex_valid,
	input  logic                  vertex_ready,
	output chb_pkg::vertex_word_t vertex
);

	chb_pkg::dp_op_t     op;
	chb_pkg::dp_status_t status;

	chb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .point_valid(point_valid),
		.final_point(point.final_point), .status(status), .point_ready(point_ready),
		.op(op)
	);

	chb_datapath u_datapath (
		.clk(clk), .arst_n(arst_n), .op(op), .point_acc(point_valid && point_ready),
		.point(point), .status(status), .vertex_valid(vertex_valid),
		.vertex_ready(vertex_ready), .vertex(vertex)
	);

`ifndef ASSERT_OFF
	a_idle_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		point_ready && vertex_valid |-> vertex.final_vertex)
		else $error("A word other than the last vertex is pending while loading.");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid |-> vertex.vertex_count != '0)
		else $error("A vertex word carries a zero vertex count.");

	a_vertex_held: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && !vertex_ready |=> vertex_valid && $stable(vertex))
		else $error("A waiting vertex word changed or was dropped.");
`endif

endmodule

// ===== rtl/chb_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Stands alone; instanced by the datapath for every store of the block.
module chb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/chb_datapath.sv =====
// Datapath of the hull builder: point, order and stack memories, counters,
// the shared multiplier pair and the output register. Uses chb_pkg and chb_ram.
module chb_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  chb_pkg::dp_op_t       op,
	input  logic                  point_acc,
	input  chb_pkg::point_word_t  point,
	output chb_pkg::dp_status_t   status,
	output logic                  vertex_valid,
	input  logic                  vertex_ready,
	output chb_pkg::vertex_word_t vertex
);

	chb_pkg::cnt_t n_q, i_q, j_q, sp_q, k_q;
	logic          ovf_q;
	chb_pkg::idx_t piv_q, key_idx_q, prev_idx_q, c_idx_q;
	chb_pkg::pt_t  best_q, p0_q, key_pt_q, prev_pt_q, c_pt_q, a_pt_q, b_pt_q;
	chb_pkg::prod_t p1_q, p2_q;
	logic          gt_q, eq_q;
	chb_pkg::sum_t dk_q, sum;
	chb_pkg::vertex_word_t vertex_q;
	logic          vertex_valid_q;

	logic          pt_we, pt_re, ord_we, ord_re, stk_we, stk_re;
	chb_pkg::idx_t pt_raddr, ord_waddr, ord_wdata, ord_raddr, stk_raddr;
	chb_pkg::idx_t ord_rd, stk_rd;
	chb_pkg::pt_t  pt_rd;

	chb_pkg::pt_t  o_pt, u_pt, v_pt;
	chb_pkg::diff_t dux, duy, dvx, dvy, m1a, m1b, m2a, m2b;
	logic          mul_en, scan_sel, out_free, k_last;

	chb_ram #(.WIDTH(chb_pkg::PT_BITS), .DEPTH(chb_pkg::MAX_POINTS)) u_pt_ram (
		.clk(clk), .we(pt_we), .waddr(n_q[chb_pkg::IDX_BITS-1:0]),
		.wdata({point.point_x, point.point_y}), .re(pt_re), .raddr(pt_raddr),
		.rdata(pt_rd)
	);

	chb_ram #(.WIDTH(chb_pkg::IDX_BITS), .DEPTH(chb_pkg::MAX_POINTS)) u_ord_ram (
		.clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
		.re(ord_re), .raddr(ord_raddr), .rdata(ord_rd)
	);

	chb_ram #(.WIDTH(chb_pkg::IDX_BITS), .DEPTH(chb_pkg::MAX_POINTS)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(sp_q[chb_pkg::IDX_BITS-1:0]), .wdata(c_idx_q),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
	);

	assign pt_we = point_acc && (n_q < chb_pkg::cnt_t'(chb_pkg::MAX_POINTS));
	assign stk_we = (op == chb_pkg::OP_PUSH);

	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = n_q[chb_pkg::IDX_BITS-1:0];
		ord_wdata = n_q[chb_pkg::IDX_BITS-1:0];
		ord_re    = 1'b0;
		ord_raddr = i_q[chb_pkg::IDX_BITS-1:0];
		pt_re     = 1'b0;
		pt_raddr  = ord_rd;
		stk_re    = 1'b0;
		stk_raddr = k_q[chb_pkg::IDX_BITS-1:0];
		if (pt_we) begin
			ord_we = 1'b1;
		end
		unique case (op)
			chb_pkg::OP_PIV_RD: begin
				pt_re    = 1'b1;
				pt_raddr = i_q[chb_pkg::IDX_BITS-1:0];
			end
			chb_pkg::OP_SWAP0: begin
				ord_we    = 1'b1;
				ord_waddr = '0;
				ord_wdata = piv_q;
			end
			chb_pkg::OP_SWAP1: begin
				ord_we    = 1'b1;
				ord_waddr = piv_q;
				ord_wdata = '0;
			end
			chb_pkg::OP_KEY_RD, chb_pkg::OP_SC_A: begin
				ord_re = 1'b1;
			end
			chb_pkg::OP_PREV_RD: begin
				ord_re    = 1'b1;
				ord_raddr = j_q[chb_pkg::IDX_BITS-1:0] - 1'b1;
			end
			chb_pkg::OP_KEY_IDX, chb_pkg::OP_PREV_IDX, chb_pkg::OP_SC_B: begin
				pt_re = 1'b1;
			end
			chb_pkg::OP_SHIFT: begin
				ord_we    = 1'b1;
				ord_waddr = j_q[chb_pkg::IDX_BITS-1:0];
				ord_wdata = prev_idx_q;
			end
			chb_pkg::OP_PLACE: begin
				ord_we    = 1'b1;
				ord_waddr = j_q[chb_pkg::IDX_BITS-1:0];
				ord_wdata = key_idx_q;
			end
			chb_pkg::OP_POP: begin
				stk_re    = 1'b1;
				stk_raddr = sp_q[chb_pkg::IDX_BITS-1:0] - chb_pkg::idx_t'(3);
			end
			chb_pkg::OP_POP_B, chb_pkg::OP_OUT_B: begin
				pt_re    = 1'b1;
				pt_raddr = stk_rd;
			end
			chb_pkg::OP_OUT_A: begin
				stk_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign scan_sel = (op == chb_pkg::OP_SC_TURN);
	assign o_pt = scan_sel ? a_pt_q : p0_q;
	assign u_pt = scan_sel ? b_pt_q : key_pt_q;
	assign v_pt = scan_sel ? c_pt_q : prev_pt_q;
	assign dux  = chb_pkg::sub_coord(u_pt.x, o_pt.x);
	assign duy  = chb_pkg::sub_coord(u_pt.y, o_pt.y);
	assign dvx  = chb_pkg::sub_coord(v_pt.x, o_pt.x);
	assign dvy  = chb_pkg::sub_coord(v_pt.y, o_pt.y);

	always_comb begin
		mul_en = 1'b1;
		m1a = dux;
		m1b = dvy;
		m2a = dvx;
		m2b = duy;
		unique case (op)
			chb_pkg::OP_S_TURN, chb_pkg::OP_SC_TURN: begin
			end
			chb_pkg::OP_S_DK: begin
				m1b = dux;
				m2a = duy;
			end
			chb_pkg::OP_S_DP: begin
				m1a = dvx;
				m1b = dvx;
				m2a = dvy;
				m2b = dvy;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign sum = chb_pkg::sum_t'(p1_q) + chb_pkg::sum_t'(p2_q);
	assign out_free = !vertex_valid_q || vertex_ready;
	assign k_last = ((k_q + 1'b1) == sp_q);

	assign status = '{
		i_lt_n:   (i_q < n_q),
		j_gt1:    (j_q > chb_pkg::cnt_t'(1)),
		ahead:    gt_q || (eq_q && (dk_q < sum)),
		sp_ge2:   (sp_q >= chb_pkg::cnt_t'(2)),
		sp_ge3:   (sp_q >= chb_pkg::cnt_t'(3)),
		turn_le0: !(p1_q > p2_q),
		out_free: out_free,
		k_last:   k_last
	};

	always_ff @(posedge clk) begin
		if (mul_en) begin
			p1_q <= chb_pkg::prod_t'(m1a) * chb_pkg::prod_t'(m1b);
			p2_q <= chb_pkg::prod_t'(m2a) * chb_pkg::prod_t'(m2b);
		end
		unique case (op)
			chb_pkg::OP_PIV_CMP: begin
				if (i_q == '0 || pt_rd.y < best_q.y ||
						(pt_rd.y == best_q.y && pt_rd.x < best_q.x)) begin
					best_q <= pt_rd;
					piv_q  <= i_q[chb_pkg::IDX_BITS-1:0];
				end
			end
			chb_pkg::OP_SWAP1: p0_q <= best_q;
			chb_pkg::OP_KEY_IDX: key_idx_q <= ord_rd;
			chb_pkg::OP_KEY_PT: key_pt_q <= pt_rd;
			chb_pkg::OP_PREV_IDX: prev_idx_q <= ord_rd;
			chb_pkg::OP_PREV_PT: prev_pt_q <= pt_rd;
			chb_pkg::OP_S_DK: begin
				gt_q <= (p1_q > p2_q);
				eq_q <= (p1_q == p2_q);
			end
			chb_pkg::OP_S_DP: dk_q <= sum;
			chb_pkg::OP_SC_B: c_idx_q <= ord_rd;
			chb_pkg::OP_SC_C: c_pt_q <= pt_rd;
			chb_pkg::OP_POP: b_pt_q <= a_pt_q;
			chb_pkg::OP_POP_C: a_pt_q <= pt_rd;
			chb_pkg::OP_PUSH: begin
				a_pt_q <= b_pt_q;
				b_pt_q <= c_pt_q;
			end
			chb_pkg::OP_OUT_LOAD: begin
				if (out_free) begin
					vertex_q <= '{vertex_x: pt_rd.x, vertex_y: pt_rd.y, vertex_count: sp_q,
						final_vertex: k_last, overflowed: ovf_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			sp_q <= '0;
			k_q <= '0;
			vertex_valid_q <= 1'b0;
		end else begin
			if (point_acc) begin
				if (pt_we) begin
					n_q <= n_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (op == chb_pkg::OP_OUT_LOAD && out_free) begin
				vertex_valid_q <= 1'b1;
			end else if (vertex_ready) begin
				vertex_valid_q <= 1'b0;
			end
			unique case (op)
				chb_pkg::OP_PIV_INIT, chb_pkg::OP_SC_INIT: begin
					i_q  <= '0;
					sp_q <= '0;
				end
				chb_pkg::OP_PIV_CMP, chb_pkg::OP_PLACE: i_q <= i_q + 1'b1;
				chb_pkg::OP_SWAP1: i_q <= chb_pkg::cnt_t'(2);
				chb_pkg::OP_KEY_IDX: j_q <= i_q;
				chb_pkg::OP_SHIFT: j_q <= j_q - 1'b1;
				chb_pkg::OP_POP: sp_q <= sp_q - 1'b1;
				chb_pkg::OP_PUSH: begin
					sp_q <= sp_q + 1'b1;
					i_q  <= i_q + 1'b1;
				end
				chb_pkg::OP_OUT_INIT: k_q <= '0;
				chb_pkg::OP_OUT_LOAD: begin
					if (out_free) begin
						k_q <= k_q + 1'b1;
						if (k_last) begin
							n_q   <= '0;
							ovf_q <= 1'b0;
							sp_q  <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign vertex_valid = vertex_valid_q;
	assign vertex = vertex_q;

endmodule

// ===== rtl/chb_ctrl.sv =====
// Controller state machine of the hull builder: sequences loading, pivot search,
// insertion sort, stack scan and vertex output. Uses chb_pkg.
module chb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	input  logic                final_point,
	input  chb_pkg::dp_status_t status,
	output logic                point_ready,
	output chb_pkg::dp_op_t     op
);

	chb_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			chb_pkg::ST_IDLE: if (point_valid && final_point) state_nxt = chb_pkg::ST_PIV_INIT;
			chb_pkg::ST_PIV_INIT: state_nxt = chb_pkg::ST_PIV_ICHK;
			chb_pkg::ST_PIV_ICHK: begin
				state_nxt = status.i_lt_n ? chb_pkg::ST_PIV_RD : chb_pkg::ST_SWAP0;
			end
			chb_pkg::ST_PIV_RD: state_nxt = chb_pkg::ST_PIV_CMP;
			chb_pkg::ST_PIV_CMP: state_nxt = chb_pkg::ST_PIV_ICHK;
			chb_pkg::ST_SWAP0: state_nxt = chb_pkg::ST_SWAP1;
			chb_pkg::ST_SWAP1: state_nxt = chb_pkg::ST_SORT_ICHK;
			chb_pkg::ST_SORT_ICHK: begin
				state_nxt = status.i_lt_n ? chb_pkg::ST_KEY_RD : chb_pkg::ST_SC_INIT;
			end
			chb_pkg::ST_KEY_RD: state_nxt = chb_pkg::ST_KEY_IDX;
			chb_pkg::ST_KEY_IDX: state_nxt = chb_pkg::ST_KEY_PT;
			chb_pkg::ST_KEY_PT: state_nxt = chb_pkg::ST_JCHK;
			chb_pkg::ST_JCHK: begin
				state_nxt = status.j_gt1 ? chb_pkg::ST_PREV_RD : chb_pkg::ST_PLACE;
			end
			chb_pkg::ST_PREV_RD: state_nxt = chb_pkg::ST_PREV_IDX;
			chb_pkg::ST_PREV_IDX: state_nxt = chb_pkg::ST_PREV_PT;
			chb_pkg::ST_PREV_PT: state_nxt = chb_pkg::ST_S_TURN;
			chb_pkg::ST_S_TURN: state_nxt = chb_pkg::ST_S_DK;
			chb_pkg::ST_S_DK: state_nxt = chb_pkg::ST_S_DP;
			chb_pkg::ST_S_DP: state_nxt = chb_pkg::ST_S_DEC;
			chb_pkg::ST_S_DEC: begin
				state_nxt = status.ahead ? chb_pkg::ST_SHIFT : chb_pkg::ST_PLACE;
			end
			chb_pkg::ST_SHIFT: state_nxt = chb_pkg::ST_JCHK;
			chb_pkg::ST_PLACE: state_nxt = chb_pkg::ST_SORT_ICHK;
			chb_pkg::ST_SC_INIT: state_nxt = chb_pkg::ST_SC_ICHK;
			chb_pkg::ST_SC_ICHK: begin
				state_nxt = status.i_lt_n ? chb_pkg::ST_SC_A : chb_pkg::ST_OUT_INIT;
			end
			chb_pkg::ST_SC_A: state_nxt = chb_pkg::ST_SC_B;
			chb_pkg::ST_SC_B: state_nxt = chb_pkg::ST_SC_C;
			chb_pkg::ST_SC_C: state_nxt = chb_pkg::ST_SC_CHK;
			chb_pkg::ST_SC_CHK: begin
				state_nxt = status.sp_ge2 ? chb_pkg::ST_SC_TURN : chb_pkg::ST_PUSH;
			end
			chb_pkg::ST_SC_TURN: state_nxt = chb_pkg::ST_SC_DEC;
			chb_pkg::ST_SC_DEC: begin
				state_nxt = status.turn_le0 ? chb_pkg::ST_POP : chb_pkg::ST_PUSH;
			end
			chb_pkg::ST_POP: begin
				state_nxt = status.sp_ge3 ? chb_pkg::ST_POP_B : chb_pkg::ST_SC_CHK;
			end
			chb_pkg::ST_POP_B: state_nxt = chb_pkg::ST_POP_C;
			chb_pkg::ST_POP_C: state_nxt = chb_pkg::ST_SC_CHK;
			chb_pkg::ST_PUSH: state_nxt = chb_pkg::ST_SC_ICHK;
			chb_pkg::ST_OUT_INIT: state_nxt = chb_pkg::ST_OUT_A;
			chb_pkg::ST_OUT_A: state_nxt = chb_pkg::ST_OUT_B;
			chb_pkg::ST_OUT_B: state_nxt = chb_pkg::ST_OUT_C;
			chb_pkg::ST_OUT_C: begin
				if (status.out_free) begin
					state_nxt = status.k_last ? chb_pkg::ST_IDLE : chb_pkg::ST_OUT_A;
				end
			end
			default: state_nxt = chb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		point_ready = (state_q == chb_pkg::ST_IDLE);
		unique case (state_q)
			chb_pkg::ST_PIV_INIT: op = chb_pkg::OP_PIV_INIT;
			chb_pkg::ST_PIV_RD: op = chb_pkg::OP_PIV_RD;
			chb_pkg::ST_PIV_CMP: op = chb_pkg::OP_PIV_CMP;
			chb_pkg::ST_SWAP0: op = chb_pkg::OP_SWAP0;
			chb_pkg::ST_SWAP1: op = chb_pkg::OP_SWAP1;
			chb_pkg::ST_KEY_RD: op = chb_pkg::OP_KEY_RD;
			chb_pkg::ST_KEY_IDX: op = chb_pkg::OP_KEY_IDX;
			chb_pkg::ST_KEY_PT: op = chb_pkg::OP_KEY_PT;
			chb_pkg::ST_PREV_RD: op = chb_pkg::OP_PREV_RD;
			chb_pkg::ST_PREV_IDX: op = chb_pkg::OP_PREV_IDX;
			chb_pkg::ST_PREV_PT: op = chb_pkg::OP_PREV_PT;
			chb_pkg::ST_S_TURN: op = chb_pkg::OP_S_TURN;
			chb_pkg::ST_S_DK: op = chb_pkg::OP_S_DK;
			chb_pkg::ST_S_DP: op = chb_pkg::OP_S_DP;
			chb_pkg::ST_SHIFT: op = chb_pkg::OP_SHIFT;
			chb_pkg::ST_PLACE: op = chb_pkg::OP_PLACE;
			chb_pkg::ST_SC_INIT: op = chb_pkg::OP_SC_INIT;
			chb_pkg::ST_SC_A: op = chb_pkg::OP_SC_A;
			chb_pkg::ST_SC_B: op = chb_pkg::OP_SC_B;
			chb_pkg::ST_SC_C: op = chb_pkg::OP_SC_C;
			chb_pkg::ST_SC_TURN: op = chb_pkg::OP_SC_TURN;
			chb_pkg::ST_POP: op = chb_pkg::OP_POP;
			chb_pkg::ST_POP_B: op = chb_pkg::OP_POP_B;
			chb_pkg::ST_POP_C: op = chb_pkg::OP_POP_C;
			chb_pkg::ST_PUSH: op = chb_pkg::OP_PUSH;
			chb_pkg::ST_OUT_INIT: op = chb_pkg::OP_OUT_INIT;
			chb_pkg::ST_OUT_A: op = chb_pkg::OP_OUT_A;
			chb_pkg::ST_OUT_B: op = chb_pkg::OP_OUT_B;
			chb_pkg::ST_OUT_C: op = chb_pkg::OP_OUT_LOAD;
			default: op = chb_pkg::OP_NONE;
		endcase
	end

endmodule
